[hw/rtl/atlp_pkg.sv]
// ----------------------------------------------------------------------------
// atlp_pkg
// shared types and constants of the antialiased thick line pixel core
// ----------------------------------------------------------------------------
package atlp_pkg;

    localparam int CFB = 4;
    localparam int BFB = 8;

    localparam logic [7:0] MARK_UNTOUCHED = 8'd255;
    localparam logic [7:0] MARK_SOLID     = 8'd254;
    localparam logic [7:0] MARK_BLEND     = 8'd253;

    localparam int SQ_W  = 50;
    localparam int SQ_N  = SQ_W / 2;
    localparam int DVD_W = 48;
    localparam int DV_N  = 16;
    localparam int XSH   = 2 * BFB - CFB;
    localparam int LSH   = 2 * BFB;
    localparam int ESH   = 2 * (BFB - CFB);
    localparam int WSH   = BFB - CFB;

    typedef enum logic [2:0] {
        REG_A_ROW,
        REG_A_COL,
        REG_B_ROW,
        REG_B_COL,
        REG_STROKE,
        REG_COLOR
    } t_reg_idx;

    typedef struct packed {
        logic [23:0] bg;
        logic [7:0]  mark;
        logic [23:0] canvas;
    } t_side;

    typedef struct packed {
        logic [SQ_W-1:0]  x;
        logic [SQ_W-1:0]  r;
        logic [DVD_W-1:0] dvd;
        logic             perp;
    } t_sq;

    typedef struct packed {
        logic [DVD_W-1:0] rem;
        logic [SQ_N-1:0]  dv;
        logic [DV_N-1:0]  q;
        logic [DV_N-1:0]  dend;
        logic             sat;
        logic             perp;
    } t_dv;

endpackage

[hw/rtl/antialiased_thick_line_pixel_core.sv]
// ----------------------------------------------------------------------------
// antialiased_thick_line_pixel_core
// shades one pixel of a thick round-capped line from its distance to the segment
//
//   channel   direction  handshake         payload
//   pixel in  in         i_valid/o_stall   row, col, background color/mark, canvas
//   pixel out out        o_valid/i_stall   changed flag, canvas color, mark
//   config    in         apb-style         endpoints, stroke width, line color
//
// one transaction per cycle sustained while the output is not stalled
// latency is set by the 25-step square root and the 16-step divider stages
// synchronous active-low reset clears valid bits and config registers, but sets stroke width to 8
// a stall freezes the pipeline only once the output skid register is full
// ----------------------------------------------------------------------------
module antialiased_thick_line_pixel_core
    import atlp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [11:0] i_pixel_row,
    input  logic [11:0] i_pixel_col,
    input  logic [23:0] i_background_color,
    input  logic [7:0]  i_background_mark,
    input  logic [23:0] i_canvas_color,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_pixel_changed,
    output logic [23:0] o_canvas_out,
    output logic [7:0]  o_mark_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = 4 + SQ_N + 1 + DV_N + 2;

    function automatic t_sq sq_step(input t_sq a, input int k);
        t_sq             o;
        logic [SQ_W-1:0] b;
        logic [SQ_W:0]   t;
        o = a;
        b = SQ_W'(1) << (2 * k);
        t = {1'b0, a.r} + {1'b0, b};
        if ({1'b0, a.x} >= t) begin
            o.x = a.x - t[SQ_W-1:0];
            o.r = (a.r >> 1) + b;
        end else begin
            o.r = a.r >> 1;
        end
        return o;
    endfunction

    function automatic t_dv dv_step(input t_dv a, input int k);
        t_dv              o;
        logic [DVD_W-1:0] s;
        o = a;
        s = DVD_W'(a.dv) << k;
        if (a.rem >= s) begin
            o.rem  = a.rem - s;
            o.q[k] = 1'b1;
        end
        return o;
    endfunction

    // config registers
    logic signed [15:0] r_a_row, r_a_col, r_b_row, r_b_col;
    logic [9:0]         r_stroke;
    logic [23:0]        r_color;

    logic w_wr;
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_row  <= '0;
            r_a_col  <= '0;
            r_b_row  <= '0;
            r_b_col  <= '0;
            r_stroke <= 10'd8;
            r_color  <= '0;
        end else if (w_wr) begin
            case (t_reg_idx'(paddr[4:2]))
                REG_A_ROW:  r_a_row  <= pwdata[15:0];
                REG_A_COL:  r_a_col  <= pwdata[15:0];
                REG_B_ROW:  r_b_row  <= pwdata[15:0];
                REG_B_COL:  r_b_col  <= pwdata[15:0];
                REG_STROKE: r_stroke <= pwdata[9:0];
                REG_COLOR:  r_color  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[4:2]))
            REG_A_ROW:  prdata = {16'd0, r_a_row};
            REG_A_COL:  prdata = {16'd0, r_a_col};
            REG_B_ROW:  prdata = {16'd0, r_b_row};
            REG_B_COL:  prdata = {16'd0, r_b_col};
            REG_STROKE: prdata = {22'd0, r_stroke};
            REG_COLOR:  prdata = {8'd0, r_color};
            default:    prdata = '0;
        endcase
    end

    // pipeline control
    logic             r_vld [DEPTH];
    t_side            r_side [DEPTH];
    logic             r_out_vld, r_skd_vld;
    logic             w_adv;

    assign w_adv   = !r_skd_vld;
    assign o_stall = r_skd_vld;
    assign o_valid = r_out_vld;

    // stage 0: differences
    logic signed [16:0] r_er, r_ec;
    logic signed [17:0] r_ar, r_ac, r_br, r_bc;
    logic signed [17:0] w_pr, w_pc;

    assign w_pr = $signed({2'b00, i_pixel_row, {CFB{1'b0}}});
    assign w_pc = $signed({2'b00, i_pixel_col, {CFB{1'b0}}});

    // stage 1: products
    logic signed [35:0] r_erar, r_ecac, r_erbr, r_ecbc, r_erer, r_ecec;
    logic signed [35:0] r_erac, r_arec, r_arar, r_acac, r_brbr, r_bcbc;

    // stage 2: sums and case select
    logic signed [36:0] n_pp1, n_pp2n, n_len2, n_sa, n_sb;
    logic               n_perp;
    logic [SQ_W-1:0]    n_sqin;
    logic               r_perp;
    logic [SQ_W-1:0]    r_sqin;
    logic signed [36:0] r_xdiff;

    always_comb begin
        n_pp1  = 37'(r_erar) + 37'(r_ecac);
        n_pp2n = 37'(r_erbr) + 37'(r_ecbc);
        n_len2 = 37'(r_erer) + 37'(r_ecec);
        n_sa   = 37'(r_arar) + 37'(r_acac);
        n_sb   = 37'(r_brbr) + 37'(r_bcbc);
        n_perp = !n_pp1[36] && (n_pp2n[36] || (n_pp2n == '0));
        if (n_perp) begin
            n_sqin = SQ_W'($unsigned(n_len2)) << LSH;
        end else if (n_pp1[36]) begin
            n_sqin = SQ_W'($unsigned(n_sa)) << ESH;
        end else begin
            n_sqin = SQ_W'($unsigned(n_sb)) << ESH;
        end
    end

    // stage 3 and square root stages
    t_sq             r_sq [SQ_N+1];
    t_sq             n_sq [SQ_N+1];
    logic [36:0]     w_cross;

    assign w_cross = r_xdiff[36] ? $unsigned(-r_xdiff) : $unsigned(r_xdiff);

    always_comb begin
        n_sq[0].x    = r_sqin;
        n_sq[0].r    = '0;
        n_sq[0].dvd  = DVD_W'(w_cross) << XSH;
        n_sq[0].perp = r_perp;
        for (int j = 0; j < SQ_N; j++) begin
            n_sq[j+1] = sq_step(r_sq[j], SQ_N - 1 - j);
        end
    end

    // divider setup and divider stages
    t_dv             r_dv [DV_N+1];
    t_dv             n_dv [DV_N+1];
    logic [SQ_N-1:0] w_root;

    assign w_root = r_sq[SQ_N].r[SQ_N-1:0];

    always_comb begin
        n_dv[0].rem  = r_sq[SQ_N].dvd;
        n_dv[0].dv   = (w_root == '0) ? SQ_N'(1) : w_root;
        n_dv[0].q    = '0;
        n_dv[0].dend = w_root[DV_N-1:0];
        n_dv[0].perp = r_sq[SQ_N].perp;
        if (r_sq[SQ_N].perp) begin
            n_dv[0].sat = r_sq[SQ_N].dvd >= (DVD_W'(n_dv[0].dv) << DV_N);
        end else begin
            n_dv[0].sat = |w_root[SQ_N-1:DV_N];
        end
        for (int j = 0; j < DV_N; j++) begin
            n_dv[j+1] = dv_step(r_dv[j], DV_N - 1 - j);
        end
    end

    // stroke compare
    logic [16:0] w_d, w_w;
    logic        n_solid, n_band;
    logic        r_c_solid, r_c_band;
    logic [7:0]  r_c_q;

    always_comb begin
        w_d     = 17'(r_dv[DV_N].perp ? r_dv[DV_N].q : r_dv[DV_N].dend);
        w_w     = 17'({r_stroke, {WSH{1'b0}}});
        n_solid = !r_dv[DV_N].sat && (w_d < w_w);
        n_band  = !r_dv[DV_N].sat && (w_d < (w_w + 17'(1 << BFB)));
    end

    // blend products
    logic signed [17:0] r_m_prod [3];
    logic signed [17:0] n_m_prod [3];
    logic               r_m_solid, r_m_band;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            n_m_prod[ch] = 18'($signed({1'b0, r_side[DEPTH-2].bg[ch*8 +: 8]})
                               - $signed({1'b0, r_color[ch*8 +: 8]}))
                          * 18'($signed({1'b0, r_c_q}));
        end
    end

    // final decision
    logic        w_chg;
    logic [23:0] w_cv, w_prop;
    logic [7:0]  w_mk;
    logic        w_closer, w_eq;
    logic [17:0] w_acc;
    logic [7:0]  w_c, w_k, w_p;

    always_comb begin
        w_closer = 1'b0;
        w_prop   = '0;
        for (int ch = 0; ch < 3; ch++) begin
            w_c   = r_color[ch*8 +: 8];
            w_k   = r_side[DEPTH-1].canvas[ch*8 +: 8];
            w_acc = 18'({w_c, 8'd0}) + $unsigned(r_m_prod[ch]);
            w_p   = w_acc[15:8];
            w_prop[ch*8 +: 8] = w_p;
            if ((w_c < w_k && w_p < w_k) || (w_c > w_k && w_p > w_k)) begin
                w_closer = 1'b1;
            end
        end
        w_eq  = (r_a_row == r_b_row) && (r_a_col == r_b_col);
        w_chg = 1'b0;
        w_cv  = r_side[DEPTH-1].canvas;
        w_mk  = r_side[DEPTH-1].mark;
        if (!w_eq) begin
            if (r_m_solid) begin
                w_chg = 1'b1;
                w_cv  = r_color;
                w_mk  = MARK_SOLID;
            end else if (r_m_band && (w_mk == MARK_UNTOUCHED
                                      || (w_mk == MARK_BLEND && w_closer))) begin
                w_chg = 1'b1;
                w_cv  = w_prop;
                w_mk  = MARK_BLEND;
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DEPTH; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < DEPTH; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= '{bg: i_background_color, mark: i_background_mark,
                           canvas: i_canvas_color};
            for (int s = 1; s < DEPTH; s++) begin
                r_side[s] <= r_side[s-1];
            end
            r_er <= 17'(r_b_row) - 17'(r_a_row);
            r_ec <= 17'(r_b_col) - 17'(r_a_col);
            r_ar <= w_pr - 18'(r_a_row);
            r_ac <= w_pc - 18'(r_a_col);
            r_br <= w_pr - 18'(r_b_row);
            r_bc <= w_pc - 18'(r_b_col);
            r_erar <= 36'(r_er) * 36'(r_ar);
            r_ecac <= 36'(r_ec) * 36'(r_ac);
            r_erbr <= 36'(r_er) * 36'(r_br);
            r_ecbc <= 36'(r_ec) * 36'(r_bc);
            r_erer <= 36'(r_er) * 36'(r_er);
            r_ecec <= 36'(r_ec) * 36'(r_ec);
            r_erac <= 36'(r_er) * 36'(r_ac);
            r_arec <= 36'(r_ar) * 36'(r_ec);
            r_arar <= 36'(r_ar) * 36'(r_ar);
            r_acac <= 36'(r_ac) * 36'(r_ac);
            r_brbr <= 36'(r_br) * 36'(r_br);
            r_bcbc <= 36'(r_bc) * 36'(r_bc);
            r_perp  <= n_perp;
            r_sqin  <= n_sqin;
            r_xdiff <= 37'(r_erac) - 37'(r_arec);
            for (int j = 0; j <= SQ_N; j++) begin
                r_sq[j] <= n_sq[j];
            end
            for (int j = 0; j <= DV_N; j++) begin
                r_dv[j] <= n_dv[j];
            end
            r_c_solid <= n_solid;
            r_c_band  <= n_band;
            r_c_q     <= w_d[7:0] - w_w[7:0];
            for (int ch = 0; ch < 3; ch++) begin
                r_m_prod[ch] <= n_m_prod[ch];
            end
            r_m_solid <= r_c_solid;
            r_m_band  <= r_c_band;
        end
    end

    // output register and skid
    logic        r_skd_chg;
    logic [23:0] r_skd_cv;
    logic [7:0]  r_skd_mk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (r_skd_vld) begin
            if (!i_stall) begin
                r_skd_vld <= 1'b0;
            end
        end else if (!r_out_vld || !i_stall) begin
            r_out_vld <= r_vld[DEPTH-1];
        end else if (r_vld[DEPTH-1]) begin
            r_skd_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_vld) begin
            if (!i_stall) begin
                o_pixel_changed <= r_skd_chg;
                o_canvas_out    <= r_skd_cv;
                o_mark_out      <= r_skd_mk;
            end
        end else if (!r_out_vld || !i_stall) begin
            o_pixel_changed <= w_chg;
            o_canvas_out    <= w_cv;
            o_mark_out      <= w_mk;
        end else begin
            r_skd_chg <= w_chg;
            r_skd_cv  <= w_cv;
            r_skd_mk  <= w_mk;
        end
    end

endmodule

[hw/rtl/atlp_chk.sv]
// ----------------------------------------------------------------------------
// atlp_chk
// port-level checks of the antialiased thick line pixel core
// ----------------------------------------------------------------------------
module atlp_chk
    import atlp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [11:0] i_pixel_row,
    input logic [11:0] i_pixel_col,
    input logic [23:0] i_background_color,
    input logic [7:0]  i_background_mark,
    input logic [23:0] i_canvas_color,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_pixel_changed,
    input logic [23:0] o_canvas_out,
    input logic [7:0]  o_mark_out,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [4:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_canvas_out)
            && $stable(o_mark_out) && $stable(o_pixel_changed))
        else $error("stalled output transaction changed");

    a_mark_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pixel_changed |-> o_mark_out == MARK_SOLID
            || o_mark_out == MARK_BLEND)
        else $error("written pixel carries a bad mark");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no output pending");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall without output stall");

endmodule

bind antialiased_thick_line_pixel_core atlp_chk u_atlp_chk (.*);

[verif/tb_antialiased_thick_line_pixel_core.sv]
// ----------------------------------------------------------------------------
// tb_antialiased_thick_line_pixel_core
// drives pixels of several line settings through the core and compares every
// result transaction against a built-in distance and blend predictor
// ----------------------------------------------------------------------------
module tb_antialiased_thick_line_pixel_core;
    import atlp_pkg::*;

    typedef struct {
        logic [11:0] row;
        logic [11:0] col;
        logic [23:0] bg;
        logic [7:0]  mark;
        logic [23:0] canvas;
    } t_pixel;

    typedef struct packed {
        logic        changed;
        logic [23:0] color;
        logic [7:0]  mark;
    } t_shade;

    typedef struct {
        t_pixel pix;
        logic   known;
        t_shade want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [11:0] i_pixel_row = '0;
    logic [11:0] i_pixel_col = '0;
    logic [23:0] i_background_color = '0;
    logic [7:0]  i_background_mark = '0;
    logic [23:0] i_canvas_color = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_pixel_changed;
    logic [23:0] o_canvas_out;
    logic [7:0]  o_mark_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    antialiased_thick_line_pixel_core dut (.*);

    always #10 i_clk = ~i_clk;

    logic signed [15:0] line_a_row, line_a_col, line_b_row, line_b_col;
    logic [9:0]         line_stroke;
    logic [23:0]        line_rgb;

    t_shade      pending_shades[$];
    int          errors = 0;
    int          sender_idle = 0;
    int          receiver_idle = 0;
    logic        hold_off = 1'b0;

    function automatic logic [63:0] root64(logic [63:0] x);
        logic [63:0] res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > x) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (x >= res + bit_v) begin
                x = x - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    function automatic t_shade shade_pixel(t_pixel p);
        t_shade s;
        longint pr, pc, er, ec, ar, ac, br, bc, dot_a, dot_b, crs, acc, c, b, k, pv;
        logic [63:0] dval, wid, lenhp, prop;
        logic closer;
        s.changed = 1'b0;
        s.color = p.canvas;
        s.mark = p.mark;
        if (line_a_row == line_b_row && line_a_col == line_b_col) return s;
        pr = longint'(p.row) * 16;
        pc = longint'(p.col) * 16;
        er = longint'(line_b_row) - longint'(line_a_row);
        ec = longint'(line_b_col) - longint'(line_a_col);
        ar = pr - line_a_row;
        ac = pc - line_a_col;
        br = pr - line_b_row;
        bc = pc - line_b_col;
        dot_a = er * ar + ec * ac;
        dot_b = -er * br - ec * bc;
        if (dot_a >= 0 && dot_b >= 0) begin
            lenhp = root64(64'(er * er + ec * ec) << 16);
            crs = er * ac - ar * ec;
            if (crs < 0) crs = -crs;
            if (lenhp == 0) lenhp = 1;
            dval = (64'(crs) << 12) / lenhp;
        end else if (dot_a < 0) begin
            dval = root64(64'(ar * ar + ac * ac) << 8);
        end else begin
            dval = root64(64'(br * br + bc * bc) << 8);
        end
        wid = 64'(line_stroke) << 4;
        if (dval < wid) begin
            s.changed = 1'b1;
            s.color = line_rgb;
            s.mark = MARK_SOLID;
            return s;
        end
        if (dval >= wid + 256) return s;
        prop = 0;
        closer = 1'b0;
        for (int ch = 0; ch < 3; ch++) begin
            c = line_rgb[ch*8 +: 8];
            b = p.bg[ch*8 +: 8];
            k = p.canvas[ch*8 +: 8];
            acc = c * 256 + (b - c) * longint'(dval - wid);
            pv = (acc >>> 8) & 255;
            prop[ch*8 +: 8] = pv[7:0];
            if ((c < k && pv < k) || (c > k && pv > k)) closer = 1'b1;
        end
        if (p.mark == MARK_UNTOUCHED || (p.mark == MARK_BLEND && closer)) begin
            s.changed = 1'b1;
            s.color = prop[23:0];
            s.mark = MARK_BLEND;
        end
        return s;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 5'(idx) << 2;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_A_ROW:  line_a_row = value[15:0];
            REG_A_COL:  line_a_col = value[15:0];
            REG_B_ROW:  line_b_row = value[15:0];
            REG_B_COL:  line_b_col = value[15:0];
            REG_STROKE: line_stroke = value[9:0];
            REG_COLOR:  line_rgb = value[23:0];
            default: ;
        endcase
    endtask

    task automatic set_line(logic [15:0] ar, logic [15:0] ac, logic [15:0] br,
                            logic [15:0] bc, logic [9:0] w, logic [23:0] rgb);
        write_reg(REG_A_ROW, {16'd0, ar});
        write_reg(REG_A_COL, {16'd0, ac});
        write_reg(REG_B_ROW, {16'd0, br});
        write_reg(REG_B_COL, {16'd0, bc});
        write_reg(REG_STROKE, {22'd0, w});
        write_reg(REG_COLOR, {8'd0, rgb});
    endtask

    task automatic send_pixel(t_pixel p);
        while (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_row <= p.row;
        i_pixel_col <= p.col;
        i_background_color <= p.bg;
        i_background_mark <= p.mark;
        i_canvas_color <= p.canvas;
        pending_shades.push_back(shade_pixel(p));
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (pending_shades.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic t_pixel near_pixel();
        t_pixel p;
        int lo_r, hi_r, lo_c, hi_c, pad;
        pad = line_stroke / 16 + 3;
        lo_r = ((line_a_row < line_b_row ? line_a_row : line_b_row) >>> 4) - pad;
        hi_r = ((line_a_row > line_b_row ? line_a_row : line_b_row) >>> 4) + pad;
        lo_c = ((line_a_col < line_b_col ? line_a_col : line_b_col) >>> 4) - pad;
        hi_c = ((line_a_col > line_b_col ? line_a_col : line_b_col) >>> 4) + pad;
        if (lo_r < 0) lo_r = 0;
        if (lo_c < 0) lo_c = 0;
        if (hi_r > 4095) hi_r = 4095;
        if (hi_c > 4095) hi_c = 4095;
        if (hi_r < lo_r) hi_r = lo_r;
        if (hi_c < lo_c) hi_c = lo_c;
        p.row = $urandom_range(99) < 85 ? 12'($urandom_range(hi_r, lo_r)) : 12'($urandom);
        p.col = $urandom_range(99) < 85 ? 12'($urandom_range(hi_c, lo_c)) : 12'($urandom);
        p.bg = 24'($urandom);
        p.canvas = 24'($urandom);
        case ($urandom_range(4))
            0, 1: p.mark = MARK_UNTOUCHED;
            2:    p.mark = MARK_BLEND;
            3:    p.mark = MARK_SOLID;
            default: p.mark = 8'($urandom);
        endcase
        return p;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off)
            i_stall <= 1'b1;
        else
            i_stall <= receiver_idle > 0 && $urandom_range(99) < receiver_idle;
    end

    always @(posedge i_clk) begin
        t_shade w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_shades.size() == 0) begin
                report_mismatch("unexpected transaction", 0, 0);
            end else begin
                w = pending_shades.pop_front();
                if (o_pixel_changed !== w.changed)
                    report_mismatch("pixel_changed", o_pixel_changed, w.changed);
                if (o_canvas_out !== w.color)
                    report_mismatch("canvas_out", o_canvas_out, w.color);
                if (o_mark_out !== w.mark)
                    report_mismatch("mark_out", o_mark_out, w.mark);
            end
        end
    end

    initial begin
        #40000000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_row   rows[$];
        t_pixel p;
        t_shade got;

        line_a_row = 0; line_a_col = 0; line_b_row = 0; line_b_col = 0;
        line_stroke = 8; line_rgb = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // equal endpoints after reset: inputs pass through
        rows.push_back('{'{12'd0, 12'd0, 24'h123456, MARK_UNTOUCHED, 24'habcdef}, 1'b1,
                         '{1'b0, 24'habcdef, MARK_UNTOUCHED}});
        rows.push_back('{'{12'hfff, 12'hfff, 24'hffffff, 8'h00, 24'hffffff}, 1'b1,
                         '{1'b0, 24'hffffff, 8'h00}});
        foreach (rows[i]) begin
            got = shade_pixel(rows[i].pix);
            if (got != rows[i].want) report_mismatch("directed table", 0, 0);
            send_pixel(rows[i].pix);
        end
        drain();

        // horizontal line, row 10, cols 5..20, radius 2, red
        set_line(16'd160, 16'd80, 16'd160, 16'd320, 10'd32, 24'hff0000);
        rows.delete();
        // solid on the segment, any mark
        rows.push_back('{'{12'd10, 12'd10, 24'h00ff00, MARK_SOLID, 24'h000000}, 1'b1,
                         '{1'b1, 24'hff0000, MARK_SOLID}});
        // far away: unchanged
        rows.push_back('{'{12'd4000, 12'd4000, 24'h00ff00, MARK_UNTOUCHED, 24'h0000ff}, 1'b1,
                         '{1'b0, 24'h0000ff, MARK_UNTOUCHED}});
        // edge band, caps, every mark kind
        rows.push_back('{'{12'd12, 12'd10, 24'h00ff00, MARK_UNTOUCHED, 24'h00ff00}, 1'b0, '{0,0,0}});
        rows.push_back('{'{12'd8, 12'd12, 24'h00ff00, MARK_BLEND, 24'h00ff00}, 1'b0, '{0,0,0}});
        rows.push_back('{'{12'd8, 12'd12, 24'h00ff00, MARK_BLEND, 24'hff0000}, 1'b0, '{0,0,0}});
        rows.push_back('{'{12'd12, 12'd12, 24'h00ff00, MARK_SOLID, 24'h00ff00}, 1'b0, '{0,0,0}});
        rows.push_back('{'{12'd12, 12'd12, 24'h00ff00, 8'd7, 24'h00ff00}, 1'b0, '{0,0,0}});
        rows.push_back('{'{12'd10, 12'd3, 24'hffffff, MARK_UNTOUCHED, 24'h0}, 1'b0, '{0,0,0}});
        rows.push_back('{'{12'd10, 12'd22, 24'hffffff, MARK_UNTOUCHED, 24'h0}, 1'b0, '{0,0,0}});
        rows.push_back('{'{12'd11, 12'd4, 24'h808080, MARK_UNTOUCHED, 24'h0}, 1'b0, '{0,0,0}});
        rows.push_back('{'{12'd0, 12'd0, 24'h0, MARK_UNTOUCHED, 24'h0}, 1'b0, '{0,0,0}});
        foreach (rows[i]) begin
            if (rows[i].known && shade_pixel(rows[i].pix) != rows[i].want)
                report_mismatch("directed table", 0, 0);
            send_pixel(rows[i].pix);
        end
        drain();

        // extreme endpoints and widest stroke
        set_line(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 10'd1023, 24'hffffff);
        for (int i = 0; i < 8; i++) begin
            p.row = i[0] ? 12'hfff : 12'd0;
            p.col = i[1] ? 12'hfff : 12'd0;
            p.bg = 24'($urandom);
            p.canvas = 24'($urandom);
            p.mark = i[2] ? MARK_BLEND : MARK_UNTOUCHED;
            send_pixel(p);
        end
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            sender_idle = phase == 0 ? 38 : phase == 1 ? 49 : 0;
            receiver_idle = phase == 0 ? 49 : phase == 1 ? 38 : 0;
            for (int g = 0; g < 5; g++) begin
                if (g == 4)
                    set_line(16'd0, 16'd0, 16'd0, 16'd0, 10'd0, 24'($urandom));
                else
                    set_line(16'($urandom_range(1200)), 16'($urandom_range(1200)),
                             16'($urandom_range(1200)), 16'($urandom_range(1200)),
                             10'($urandom_range(g == 0 ? 0 : 80)), 24'($urandom));
                if (phase == 1 && g == 2) begin
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (200) @(posedge i_clk);
                            hold_off = 1'b0;
                        end
                        begin
                            for (int i = 0; i < 70; i++) send_pixel(near_pixel());
                            i_valid <= 1'b0;
                        end
                    join
                end else begin
                    for (int i = 0; i < 26; i++) send_pixel(near_pixel());
                end
                drain();
            end
        end

        drain();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
